/* rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	typedef enum logic [2:0] {
		M_IDLE,
		M_BODY,
		M_ESC,
		M_HEX,
		M_HELD,
		M_HELD_ESC,
		M_PAIR_HEX,
		M_DONE
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] acc;
		logic [15:0] held;
		logic [2:0]  cnt;
		logic        bad;
	} state_t;

	typedef logic [2:0] status_t;

	localparam status_t ST_RUN      = 3'd0;
	localparam status_t ST_OK       = 3'd1;
	localparam status_t ST_NO_OPEN  = 3'd2;
	localparam status_t ST_NO_CLOSE = 3'd3;
	localparam status_t ST_SHORT_U  = 3'd4;
	localparam status_t ST_BAD_HEX  = 3'd5;

	localparam int unsigned MaxResults = 5;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		status_t    status;
	} res_t;

	typedef struct packed {
		res_t [MaxResults-1:0] item;
		logic [2:0]            count;
	} batch_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} utf8_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;

	localparam logic [7:0] BYTE_BS  = 8'h08;
	localparam logic [7:0] BYTE_FF  = 8'h0C;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_TAB = 8'h09;

	localparam logic [15:0] SURR_BELOW = 16'hD7FF;
	localparam logic [15:0] SURR_ABOVE = 16'hE000;
	localparam logic [15:0] PAIR_LO    = 16'h00D8;
	localparam logic [15:0] PAIR_HI    = 16'h00DF;
	localparam logic [20:0] CP_OFFSET  = 21'h10000;
	localparam logic [2:0]  HEX_DIGITS = 3'd4;
	localparam logic [2:0]  HALF_DIGITS = 3'd2;

	// bit 4 flags a byte that is not a hex digit
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b0, c[3:0]};
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r = {1'b0, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t u;
		u = '0;
		if (cp <= 21'h7F) begin
			u.b[0] = cp[7:0];
			u.len  = 3'd1;
		end else if (cp <= 21'h7FF) begin
			u.b[0] = {3'b110, cp[10:6]};
			u.b[1] = {2'b10, cp[5:0]};
			u.len  = 3'd2;
		end else if (cp <= 21'hFFFF) begin
			u.b[0] = {4'b1110, cp[15:12]};
			u.b[1] = {2'b10, cp[11:6]};
			u.b[2] = {2'b10, cp[5:0]};
			u.len  = 3'd3;
		end else begin
			u.b[0] = {5'b11110, cp[20:18]};
			u.b[1] = {2'b10, cp[17:12]};
			u.b[2] = {2'b10, cp[11:6]};
			u.b[3] = {2'b10, cp[5:0]};
			u.len  = 3'd4;
		end
		return u;
	endfunction

endpackage

/* rtl/jsu_decode.sv */
// ----------------------------------------------------------------------------
// jsu_decode
// Next-state and result-batch logic for one source byte.
// ----------------------------------------------------------------------------
module jsu_decode (
	input  logic [7:0]      in_byte,
	input  logic            first_of_buffer,
	input  logic            last_of_buffer,
	input  jsu_pkg::state_t cur,
	output jsu_pkg::state_t nxt,
	output jsu_pkg::batch_t batch
);
	import jsu_pkg::*;

	logic [4:0]  hx;
	logic [15:0] acc_n;
	logic [2:0]  cnt_n;
	logic        bad_n;
	logic        u_en;
	logic [20:0] u_cp;
	logic        x_en;
	logic [7:0]  x_byte;
	logic        t_en;
	status_t     t_st;
	logic        body_en;
	logic        esc_en;
	utf8_t       u;
	logic [2:0]  ulen;

	// shared hex digit intake
	assign hx    = hex_nib(in_byte);
	assign acc_n = {cur.acc[11:0], (hx[4] ? 4'h0 : hx[3:0])};
	assign cnt_n = cur.cnt + 3'd1;
	assign bad_n = cur.bad | hx[4];

	always_comb begin
		nxt     = cur;
		u_en    = 1'b0;
		u_cp    = '0;
		x_en    = 1'b0;
		x_byte  = '0;
		t_en    = 1'b0;
		t_st    = ST_RUN;
		body_en = 1'b0;
		esc_en  = 1'b0;
		if (first_of_buffer) begin
			nxt      = '0;
			nxt.mode = M_BODY;
			if (in_byte != CH_QUOTE) begin
				t_en     = 1'b1;
				t_st     = ST_NO_OPEN;
				nxt.mode = M_DONE;
			end
		end else begin
			case (cur.mode)
				M_BODY: body_en = 1'b1;
				M_ESC: esc_en = 1'b1;
				M_HEX: begin
					nxt.acc = acc_n;
					nxt.cnt = cnt_n;
					nxt.bad = bad_n;
					if (cnt_n >= HEX_DIGITS) begin
						if (bad_n) begin
							t_en     = 1'b1;
							t_st     = ST_BAD_HEX;
							nxt.mode = M_DONE;
							nxt.held = '0;
						end else if (acc_n > SURR_BELOW && acc_n < SURR_ABOVE) begin
							nxt.held = acc_n;
							nxt.mode = M_HELD;
						end else begin
							u_en     = 1'b1;
							u_cp     = {5'd0, acc_n};
							nxt.mode = M_BODY;
						end
					end
				end
				M_HELD: begin
					if (in_byte == CH_BSLASH) begin
						nxt.mode = M_HELD_ESC;
					end else begin
						u_en    = 1'b1;
						u_cp    = {5'd0, cur.held};
						body_en = 1'b1;
					end
				end
				M_HELD_ESC: begin
					if (in_byte == CH_LOW_U) begin
						nxt.mode = M_PAIR_HEX;
						nxt.acc  = '0;
						nxt.cnt  = '0;
						nxt.bad  = 1'b0;
					end else begin
						u_en   = 1'b1;
						u_cp   = {5'd0, cur.held};
						esc_en = 1'b1;
					end
				end
				M_PAIR_HEX: begin
					nxt.acc = acc_n;
					nxt.cnt = cnt_n;
					nxt.bad = bad_n;
					// two digits already rule out any surrogate: flush the held one
					if (cnt_n == HALF_DIGITS && !bad_n &&
					    !(acc_n >= PAIR_LO && acc_n <= PAIR_HI)) begin
						u_en     = 1'b1;
						u_cp     = {5'd0, cur.held};
						nxt.mode = M_HEX;
					end else if (cnt_n >= HEX_DIGITS) begin
						if (bad_n) begin
							t_en     = 1'b1;
							t_st     = ST_BAD_HEX;
							nxt.mode = M_DONE;
							nxt.held = '0;
						end else begin
							u_en     = 1'b1;
							u_cp     = {1'b0, cur.held[9:0], acc_n[9:0]} + CP_OFFSET;
							nxt.mode = M_BODY;
						end
					end
				end
				default: ;
			endcase

			if (body_en) begin
				nxt.mode = M_BODY;
				if (in_byte == CH_QUOTE) begin
					t_en     = 1'b1;
					t_st     = ST_OK;
					nxt.mode = M_DONE;
				end else if (in_byte == CH_BSLASH) begin
					nxt.mode = M_ESC;
				end else begin
					x_en   = 1'b1;
					x_byte = in_byte;
				end
			end

			if (esc_en) begin
				nxt.mode = M_BODY;
				x_en     = 1'b1;
				case (in_byte)
					CH_LOW_B: x_byte = BYTE_BS;
					CH_LOW_F: x_byte = BYTE_FF;
					CH_LOW_N: x_byte = BYTE_LF;
					CH_LOW_R: x_byte = BYTE_CR;
					CH_LOW_T: x_byte = BYTE_TAB;
					CH_LOW_U: begin
						x_en     = 1'b0;
						nxt.mode = M_HEX;
						nxt.acc  = '0;
						nxt.cnt  = '0;
						nxt.bad  = 1'b0;
					end
					default: x_byte = in_byte;
				endcase
			end
		end

		if (last_of_buffer && nxt.mode != M_DONE && nxt.mode != M_IDLE) begin
			t_en = 1'b1;
			t_st = (nxt.mode == M_HEX || nxt.mode == M_PAIR_HEX) ? ST_SHORT_U : ST_NO_CLOSE;
			nxt.mode = M_DONE;
			nxt.held = '0;
		end
	end

	assign u    = utf8_enc(u_cp);
	assign ulen = u_en ? u.len : 3'd0;

	// code point bytes first, then the plain byte, then the terminal item
	always_comb begin
		for (int i = 0; i < MaxResults; i++) begin
			if (3'(i) < ulen) begin
				batch.item[i].data   = u.b[2'(i)];
				batch.item[i].valid  = 1'b1;
				batch.item[i].status = ST_RUN;
			end else if (x_en && 3'(i) == ulen) begin
				batch.item[i].data   = x_byte;
				batch.item[i].valid  = 1'b1;
				batch.item[i].status = ST_RUN;
			end else begin
				batch.item[i].data   = '0;
				batch.item[i].valid  = 1'b0;
				batch.item[i].status = t_st;
			end
		end
		batch.count = ulen + {2'b00, x_en} + {2'b00, t_en};
	end

endmodule

/* rtl/jsu_out_buf.sv */
// ----------------------------------------------------------------------------
// jsu_out_buf
// Result register: holds one byte's batch and hands it out an item per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module jsu_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  jsu_pkg::batch_t batch,
	output logic            free,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // out_byte
	output logic [3:0]      m_axis_tuser,  // status[2:0], byte_valid
	output logic            m_axis_tlast   // run_last
);
	import jsu_pkg::*;

	res_t [MaxResults-1:0] item_q;
	logic [2:0]            cnt_q;
	logic                  take;

	assign take          = m_axis_tvalid && m_axis_tready;
	assign free          = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_axis_tready);
	assign m_axis_tvalid = (cnt_q != 3'd0);
	assign m_axis_tdata  = item_q[0].data;
	assign m_axis_tuser  = {item_q[0].status, item_q[0].valid};
	assign m_axis_tlast  = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= batch.count;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= batch.item;
		end else if (take) begin
			for (int i = 0; i < MaxResults - 1; i++) begin
				item_q[i] <= item_q[i+1];
			end
		end
	end

endmodule

/* rtl/json_string_unescape_utf8_core.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string unescaper with UTF-8 output, one source byte per transaction.
// ----------------------------------------------------------------------------
// path: a byte is held in the input stage, then its batch in the result register
// throughput: one byte per cycle while each byte yields at most one result and the sink
//   is ready; a byte yielding k results (k up to 5) holds the result register until all are taken
// reset: arst_n clears the parser to idle and empties input and result stages
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // in_byte
	input  logic       s_axis_tuser,   // first_of_buffer
	input  logic       s_axis_tlast,   // last_of_buffer
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte
	output logic [3:0] m_axis_tuser,   // status[2:0], byte_valid
	output logic       m_axis_tlast    // run_last
);
	import jsu_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;
	state_t     state_q;
	state_t     state_nxt;
	batch_t     batch;
	logic       free;
	logic       fire;

	assign fire          = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (fire) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
			last_s1  <= s_axis_tlast;
		end
	end

	jsu_decode u_decode (
		.in_byte         (byte_s1),
		.first_of_buffer (first_s1),
		.last_of_buffer  (last_s1),
		.cur             (state_q),
		.nxt             (state_nxt),
		.batch           (batch)
	);

	jsu_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire),
		.batch         (batch),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// a status transaction always closes the batch of its byte
	a_term_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("terminal status not marked last");

	a_byte_running: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[3:1] == ST_RUN)
		else $error("decoded byte carries a final status");

	a_no_return_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode != M_IDLE |=> state_q.mode != M_IDLE)
		else $error("parser fell back to idle");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1)
		else $error("input stage dropped a pending byte");

endmodule
